/* hw/rtl/primary_backup_failover_macros.svh */
// Assertion macros used by the back end of the failover monitor RTL.
`ifndef PRIMARY_BACKUP_FAILOVER_MACROS_SVH
`define PRIMARY_BACKUP_FAILOVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PBF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/pbf_pkg.sv */
// Types, constants and register indexes of the failover monitor.
`default_nettype none

package pbf_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int CMDQ_DEPTH_DEF = 2;
	localparam int RESQ_DEPTH_DEF = 2;

	localparam int NOW_W = 32;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CNT_W = 4;
	localparam int OP_W = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [OP_W-1:0] OP_SUCCESS = 2'd0;
	localparam logic [OP_W-1:0] OP_FAILURE = 2'd1;
	localparam logic [OP_W-1:0] OP_PROBE = 2'd2;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_FAILURE_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_INTERVAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAILURE_THRESHOLD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_THRESHOLD = 2'd3;

	localparam logic [CFG_W-1:0] FAILURE_WINDOW_RST = 32'd60000;
	localparam logic [CFG_W-1:0] PROBE_INTERVAL_RST = 32'd30000;
	localparam logic [CNT_W-1:0] FAILURE_THRESHOLD_RST = 4'd3;
	localparam logic [CNT_W-1:0] RECOVERY_THRESHOLD_RST = 4'd2;

	typedef enum logic [1:0] {
		K_QUERY = 2'd0,
		K_SUCCESS = 2'd1,
		K_FAILURE = 2'd2,
		K_PROBE = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [NOW_W-1:0] now;
	} cmd_t;

	typedef struct packed {
		logic on_backup;
		logic probe_due;
	} res_t;

endpackage

`default_nettype wire

/* hw/rtl/pbf_fifo.sv */
// Small register queue with full and empty flags.
`default_nettype none

module pbf_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire logic [WIDTH-1:0] wr_data,
	output logic full,
	input wire logic rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/pbf_front.sv */
// Front end: accepts input beats, classifies them and queues the commands.
`default_nettype none

module pbf_front
	import pbf_pkg::*;
#(
	parameter int CMDQ_DEPTH = CMDQ_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [OP_W-1:0] operation,
	input wire logic about_primary,
	input wire logic [NOW_W-1:0] now_ms,
	output logic cmd_valid,
	output cmd_t cmd,
	input wire logic cmd_pop
);

	cmd_t cmd_in;
	logic [$bits(cmd_t)-1:0] cmd_raw;
	logic cmd_empty;

	// Success and failure events about the backup source change nothing and become queries.
	always_comb begin
		cmd_in.now = now_ms;
		unique case (operation)
			OP_SUCCESS: cmd_in.kind = about_primary ? K_SUCCESS : K_QUERY;
			OP_FAILURE: cmd_in.kind = about_primary ? K_FAILURE : K_QUERY;
			OP_PROBE: cmd_in.kind = K_PROBE;
			OP_QUERY: cmd_in.kind = K_QUERY;
		endcase
	end

	pbf_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMDQ_DEPTH)
	) u_cmdq (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(push),
		.wr_data(cmd_in),
		.full(full),
		.rd_en(cmd_pop),
		.rd_data(cmd_raw),
		.empty(cmd_empty)
	);

	assign cmd = cmd_t'(cmd_raw);
	assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

/* hw/rtl/pbf_back.sv */
// Back end: configuration registers, health state update and result queue.
`default_nettype none
`include "primary_backup_failover_macros.svh"

module pbf_back
	import pbf_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF,
	parameter int RESQ_DEPTH = RESQ_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data,
	input wire logic cmd_valid,
	input wire cmd_t cmd,
	output logic cmd_pop,
	output logic empty,
	input wire logic pop,
	output res_t res
);

	localparam int TW = (TIME_WIDTH < NOW_W) ? TIME_WIDTH : NOW_W;

	logic [CFG_W-1:0] window_q;
	logic [CFG_W-1:0] interval_q;
	logic [CNT_W-1:0] fail_thr_q;
	logic [CNT_W-1:0] rec_thr_q;

	logic backup_q;
	logic [CNT_W-1:0] fail_cnt_q;
	logic [TW-1:0] first_fail_q;
	logic [CNT_W-1:0] rec_cnt_q;
	logic [TW-1:0] last_probe_q;

	logic backup_n;
	logic [CNT_W-1:0] fail_cnt_n;
	logic [TW-1:0] first_fail_n;
	logic [CNT_W-1:0] rec_cnt_n;
	logic [TW-1:0] last_probe_n;

	logic [TW-1:0] now_t;
	logic [TW-1:0] since_first;
	logic [TW-1:0] since_probe;
	logic [CNT_W-1:0] fail_inc;
	logic [CNT_W-1:0] rec_inc;
	logic [CNT_W-1:0] fail_next;
	logic restart;
	logic due_old;
	logic probe_now;
	logic resq_full;
	res_t res_in;
	logic [$bits(res_t)-1:0] res_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= FAILURE_WINDOW_RST;
			interval_q <= PROBE_INTERVAL_RST;
			fail_thr_q <= FAILURE_THRESHOLD_RST;
			rec_thr_q <= RECOVERY_THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FAILURE_WINDOW: window_q <= cfg_data;
				REG_PROBE_INTERVAL: interval_q <= cfg_data;
				REG_FAILURE_THRESHOLD: fail_thr_q <= cfg_data[CNT_W-1:0];
				REG_RECOVERY_THRESHOLD: rec_thr_q <= cfg_data[CNT_W-1:0];
			endcase
		end
	end

	assign cmd_pop = cmd_valid && !resq_full;

	assign now_t = cmd.now[TW-1:0];
	assign since_first = now_t - first_fail_q;
	assign since_probe = now_t - last_probe_q;
	assign fail_inc = (fail_cnt_q == CNT_MAX) ? fail_cnt_q : fail_cnt_q + CNT_W'(1);
	assign rec_inc = (rec_cnt_q == CNT_MAX) ? rec_cnt_q : rec_cnt_q + CNT_W'(1);
	assign restart = (fail_cnt_q == '0) || (now_t < first_fail_q) ||
		(NOW_W'(since_first) > window_q);
	assign fail_next = restart ? CNT_W'(1) : fail_inc;
	assign due_old = (now_t >= last_probe_q) && (NOW_W'(since_probe) >= interval_q);

	always_comb begin
		backup_n = backup_q;
		fail_cnt_n = fail_cnt_q;
		first_fail_n = first_fail_q;
		rec_cnt_n = rec_cnt_q;
		last_probe_n = last_probe_q;
		probe_now = 1'b0;
		if (cmd_pop) begin
			unique case (cmd.kind)
				K_SUCCESS: begin
					if (!backup_q) begin
						fail_cnt_n = '0;
						first_fail_n = '0;
						rec_cnt_n = '0;
					end else if (rec_inc >= rec_thr_q) begin
						backup_n = 1'b0;
						fail_cnt_n = '0;
						first_fail_n = '0;
						rec_cnt_n = '0;
						last_probe_n = '0;
					end else begin
						rec_cnt_n = rec_inc;
					end
				end
				K_FAILURE: begin
					if (backup_q) begin
						rec_cnt_n = '0;
					end else begin
						// A failure outside the window, the first one or one with earlier time restarts the count.
						fail_cnt_n = fail_next;
						first_fail_n = restart ? now_t : first_fail_q;
						if (fail_next >= fail_thr_q) begin
							backup_n = 1'b1;
							rec_cnt_n = '0;
							last_probe_n = now_t;
							probe_now = 1'b1;
						end
					end
				end
				K_PROBE: begin
					if (backup_q) begin
						last_probe_n = now_t;
						probe_now = 1'b1;
					end
				end
				K_QUERY: begin
				end
			endcase
		end
		res_in.on_backup = backup_n;
		res_in.probe_due = backup_n && (probe_now ? (interval_q == '0) : due_old);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backup_q <= 1'b0;
			fail_cnt_q <= '0;
			first_fail_q <= '0;
			rec_cnt_q <= '0;
			last_probe_q <= '0;
		end else begin
			backup_q <= backup_n;
			fail_cnt_q <= fail_cnt_n;
			first_fail_q <= first_fail_n;
			rec_cnt_q <= rec_cnt_n;
			last_probe_q <= last_probe_n;
		end
	end

	pbf_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(RESQ_DEPTH)
	) u_resq (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cmd_pop),
		.wr_data(res_in),
		.full(resq_full),
		.rd_en(pop),
		.rd_data(res_raw),
		.empty(empty)
	);

	assign res = res_t'(res_raw);

	`PBF_ASSERT_IMP(a_backup_has_failures, clk, arst_n, backup_q, fail_cnt_q != '0, "backup selected with zero failure count")
	`PBF_ASSERT_IMP(a_primary_clean, clk, arst_n, !backup_q, (rec_cnt_q == '0) && (last_probe_q == '0), "recovery state not clear on primary")
	`PBF_ASSERT_NXT(a_switch_needs_failure, clk, arst_n, !backup_q && !(cmd_pop && (cmd.kind == K_FAILURE)), !backup_q, "switch to backup without a primary failure beat")

endmodule

`default_nettype wire

/* hw/rtl/primary_backup_failover.sv */
// Top level of the primary/backup failover health monitor.
// A pushed beat is registered in the command queue, then its result in the result queue.
// Throughput: one beat per cycle unless the result queue is full and stalls the back end.
// Command and result queues (default depth 2) let either side stall without bubbles.
// Reset (arst_n low) selects the primary, clears all counters and loads default registers.
`default_nettype none

module primary_backup_failover
	import pbf_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF,
	parameter int CMDQ_DEPTH = CMDQ_DEPTH_DEF,
	parameter int RESQ_DEPTH = RESQ_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [OP_W-1:0] operation,
	input wire logic about_primary,
	input wire logic [NOW_W-1:0] now_ms,
	output logic empty,
	input wire logic pop,
	output logic on_backup,
	output logic probe_due,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;
	res_t res;

	pbf_front #(
		.CMDQ_DEPTH(CMDQ_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.about_primary(about_primary),
		.now_ms(now_ms),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop)
	);

	pbf_back #(
		.TIME_WIDTH(TIME_WIDTH),
		.RESQ_DEPTH(RESQ_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop),
		.empty(empty),
		.pop(pop),
		.res(res)
	);

	assign on_backup = res.on_backup;
	assign probe_due = res.probe_due;

endmodule

`default_nettype wire
